[rtl/rcga_pkg.sv]
// Package for the range column ground angle block.
// Holds the shared types, fixed-point constants and the arctangent table.
// Used by every module in rtl except rcga_fifo; depends on nothing.
package rcga_pkg;

   // Image size limits.
   localparam int N_BEAMS = 64;
   localparam int N_COLS  = 1800;

   // Default queue depths (powers of two, at least two).
   localparam int QUEUE_DEPTH  = 2;
   localparam int RESULT_DEPTH = 2;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_RANGE_MIN  = 2'd0,
      CSR_RANGE_MAX  = 2'd1,
      CSR_ANGLE_STEP = 2'd2,
      CSR_ANGLE_SPAN = 2'd3
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [17:0] RANGE_MIN_RESET  = 18'd500;
   localparam logic [17:0] RANGE_MAX_RESET  = 18'd120000;
   localparam logic [16:0] ANGLE_STEP_RESET = 17'd8865;
   localparam logic [21:0] ANGLE_SPAN_RESET = 22'd558504;

   // Reset values of the kept point.
   localparam logic [10:0] LAST_COL_RESET = 11'd1;

   // Angles in microradians.
   localparam logic signed [24:0] PI_URAD      = 25'sd3141593;
   localparam logic signed [24:0] HALF_PI_URAD = 25'sd1570796;
   localparam logic signed [24:0] TWO_PI_URAD  = 25'sd6283185;

   // CORDIC setup.
   localparam int                 CORDIC_ITERS      = 21;
   localparam logic signed [32:0] CORDIC_GAIN_START = 33'sd652032874;
   localparam logic signed [51:0] ROUND_HALF        = 52'sd536870912;

   // Range division by 65534 works on the halved product, divided by 2^15 - 1.
   localparam logic [16:0] RANGE_REM_ONE = 17'd32767;
   localparam logic [16:0] RANGE_REM_TWO = 17'd65534;

   // Angle division by 10000 as a multiply by ceil(2^35 / 10000).
   localparam logic [21:0] ANGLE_RECIP = 22'd3435974;
   localparam logic [8:0]  ANGLE_LIMIT = 9'd157;

   // Width of one configuration write.
   localparam int CSR_DATA_W = 22;

   // Kind of an accepted item, decided by the front part.
   typedef enum logic [1:0] {
      KIND_EMPTY   = 2'd0,
      KIND_OUTSIDE = 2'd1,
      KIND_PIXEL   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  row;
      logic [10:0] col;
      logic [15:0] code;
   } item_type;

   typedef struct packed {
      logic [7:0] angle_code;
      logic       angle_written;
   } result_type;

   typedef struct packed {
      logic [17:0] range_min_mm;
      logic [17:0] range_max_mm;
      logic [16:0] angle_step_urad;
      logic [21:0] angle_span_urad;
   } cfg_type;

   // Sequencer states of the back part.
   typedef enum logic [3:0] {
      BK_IDLE,
      BK_CHECK,
      BK_PREP,
      BK_DIV,
      BK_FIX,
      BK_FOLD,
      BK_ROT,
      BK_MUL_Z,
      BK_MUL_X,
      BK_DIFF,
      BK_VEC,
      BK_RESULT,
      BK_DONE
   } back_state_type;

   // Arctangent of 2^-i in microradians, rounded to nearest.
   function automatic logic [19:0] atan_urad(input logic [4:0] i);
      logic [19:0] v;
      case (i)
         5'd0:    v = 20'd785398;
         5'd1:    v = 20'd463648;
         5'd2:    v = 20'd244979;
         5'd3:    v = 20'd124355;
         5'd4:    v = 20'd62419;
         5'd5:    v = 20'd31240;
         5'd6:    v = 20'd15624;
         5'd7:    v = 20'd7812;
         5'd8:    v = 20'd3906;
         5'd9:    v = 20'd1953;
         5'd10:   v = 20'd977;
         5'd11:   v = 20'd488;
         5'd12:   v = 20'd244;
         5'd13:   v = 20'd122;
         5'd14:   v = 20'd61;
         5'd15:   v = 20'd31;
         5'd16:   v = 20'd15;
         5'd17:   v = 20'd8;
         5'd18:   v = 20'd4;
         5'd19:   v = 20'd2;
         5'd20:   v = 20'd1;
         default: v = 20'd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/range_column_ground_angle.sv]
// Top level of the range column ground angle block.
// Depends on rcga_pkg, rcga_fifo, rcga_front and rcga_back.
//
// Pixels enter on a queue-like port: an item is taken when req_push is high
// and req_full is low. Results leave the same way: while rsp_empty is low the
// oldest result is on rsp_angle_code and rsp_angle_written, and it is taken
// when rsp_pop is high. Every item gives exactly one result, in order.
// Registers are written through csr_write_en, csr_index and csr_wdata; the
// user must write them only while the block is idle, which the block does not
// enforce. A write takes effect at the next edge. The back part handles one
// item at a time. Empty and out-of-image pixels skip the arithmetic; other
// pixels run the range division and the 21-step CORDIC rotation, and those
// that yield an angle also the 21-step vectoring pass and the angle scaling.
// A short queue ahead of the back part takes items while it works, and a
// result queue lets it go on while the receiver stalls; when that queue is
// full the back part waits and req_full rises once the input queue fills.
// Synchronous reset empties both queues, restores the register defaults and
// sets the kept point to column 1 at the origin.
module range_column_ground_angle #(
   parameter int QUEUE_DEPTH  = rcga_pkg::QUEUE_DEPTH,
   parameter int RESULT_DEPTH = rcga_pkg::RESULT_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [5:0]                      req_pixel_row,
   input  logic [10:0]                     req_pixel_col,
   input  logic [15:0]                     req_range_code,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [7:0]                      rsp_angle_code,
   output logic                            rsp_angle_written,
   input  logic                            csr_write_en,
   input  logic [1:0]                      csr_index,
   input  logic [rcga_pkg::CSR_DATA_W-1:0] csr_wdata
);

   rcga_pkg::cfg_type    cfg_ff, cfg_in;
   rcga_pkg::item_type   item_data;
   rcga_pkg::result_type res_data, rsp_data;
   logic                 item_valid, item_pop;
   logic                 res_full, res_push;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (rcga_pkg::csr_index_type'(csr_index))
            rcga_pkg::CSR_RANGE_MIN:  cfg_in.range_min_mm    = csr_wdata[17:0];
            rcga_pkg::CSR_RANGE_MAX:  cfg_in.range_max_mm    = csr_wdata[17:0];
            rcga_pkg::CSR_ANGLE_STEP: cfg_in.angle_step_urad = csr_wdata[16:0];
            rcga_pkg::CSR_ANGLE_SPAN: cfg_in.angle_span_urad = csr_wdata[21:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_min_mm    <= rcga_pkg::RANGE_MIN_RESET;
         cfg_ff.range_max_mm    <= rcga_pkg::RANGE_MAX_RESET;
         cfg_ff.angle_step_urad <= rcga_pkg::ANGLE_STEP_RESET;
         cfg_ff.angle_span_urad <= rcga_pkg::ANGLE_SPAN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept and classify.
   rcga_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_pixel_row (req_pixel_row),
      .req_pixel_col (req_pixel_col),
      .req_range_code(req_range_code),
      .item_valid    (item_valid),
      .item_data     (item_data),
      .item_pop      (item_pop)
   );

   // Arithmetic sequencer.
   rcga_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item_valid(item_valid),
      .item_data (item_data),
      .item_pop  (item_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   // Result queue toward the receiver.
   rcga_fifo #(
      .WIDTH($bits(rcga_pkg::result_type)),
      .DEPTH(RESULT_DEPTH)
   ) u_result (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .push_data(res_data),
      .full     (res_full),
      .pop      (rsp_pop),
      .pop_data (rsp_data),
      .empty    (rsp_empty)
   );

   assign rsp_angle_code    = rsp_data.angle_code;
   assign rsp_angle_written = rsp_data.angle_written;

   // A result without an angle carries code zero.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_angle_written) |-> (rsp_angle_code == 8'd0))
      else $error("result without angle has a nonzero code");

   // The angle never exceeds its saturation limit.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_angle_code <= 8'd157))
      else $error("angle code above limit");

   // The back part only pushes into a result queue with room.
   assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into a full queue");

   // Reset leaves both channels empty.
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!req_full && rsp_empty))
      else $error("queues not empty after reset");

endmodule

[rtl/rcga_fifo.sv]
// Small first-in first-out queue of registers with full and empty flags.
// Depends on nothing; DEPTH must be a power of two of at least two.
module rcga_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/rcga_front.sv]
// Front part: accepts pixels, classifies them and queues them for the back part.
// Depends on rcga_pkg and rcga_fifo.
module rcga_front #(
   parameter int QUEUE_DEPTH = rcga_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [5:0]        req_pixel_row,
   input  logic [10:0]       req_pixel_col,
   input  logic [15:0]       req_range_code,
   output logic              item_valid,
   output rcga_pkg::item_type item_data,
   input  logic              item_pop
);

   rcga_pkg::item_type in_item;
   logic               queue_empty;

   // Empty pixels and pixels outside the image need no arithmetic.
   always_comb begin
      in_item.row  = req_pixel_row;
      in_item.col  = req_pixel_col;
      in_item.code = req_range_code;
      if (req_range_code == '0) begin
         in_item.kind = rcga_pkg::KIND_EMPTY;
      end else if (int'(req_pixel_row) >= rcga_pkg::N_BEAMS ||
                   int'(req_pixel_col) >= rcga_pkg::N_COLS) begin
         in_item.kind = rcga_pkg::KIND_OUTSIDE;
      end else begin
         in_item.kind = rcga_pkg::KIND_PIXEL;
      end
   end

   // Queue between the two parts.
   rcga_fifo #(
      .WIDTH($bits(rcga_pkg::item_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(in_item),
      .full     (req_full),
      .pop      (item_pop),
      .pop_data (item_data),
      .empty    (queue_empty)
   );

   assign item_valid = !queue_empty;

endmodule

[rtl/rcga_back.sv]
// Back part: decodes range and elevation, runs the CORDIC steps and the constant
// divisions and forms the slope angle. Depends on rcga_pkg.
module rcga_back (
   input  logic                 clock,
   input  logic                 reset,
   input  rcga_pkg::cfg_type    cfg,
   input  logic                 item_valid,
   input  rcga_pkg::item_type   item_data,
   output logic                 item_pop,
   input  logic                 res_full,
   output logic                 res_push,
   output rcga_pkg::result_type res_data
);

   rcga_pkg::back_state_type state_ff, state_in;
   rcga_pkg::item_type       item_ff, item_in;

   logic [4:0]         cnt_ff, cnt_in;
   logic [33:0]        prod_ff, prod_in;
   logic               rneg_ff, rneg_in;
   logic signed [24:0] elev_ff, elev_in;
   logic [16:0]        div_rem_ff, div_rem_in;
   logic [17:0]        div_quo_ff, div_quo_in;
   logic [17:0]        range_ff, range_in;
   logic               neg_ff, neg_in;
   logic signed [32:0] rx_ff, rx_in;
   logic signed [32:0] ry_ff, ry_in;
   logic signed [18:0] hz_ff, hz_in;
   logic signed [18:0] fx_ff, fx_in;
   logic signed [42:0] vx_ff, vx_in;
   logic signed [42:0] vy_ff, vy_in;
   logic signed [22:0] vz_ff, vz_in;
   logic [7:0]         acode_ff, acode_in;
   logic               written_ff, written_in;
   logic [10:0]        last_col_ff, last_col_in;
   logic signed [18:0] last_z_ff, last_z_in;
   logic signed [18:0] last_x_ff, last_x_in;

   // Shared arithmetic terms.
   logic signed [18:0] range_diff;
   logic [17:0]        diff_mag;
   logic [15:0]        code_m1;
   logic [22:0]        row_prod;
   logic [32:0]        rem_full;
   logic [19:0]        atan_val;
   logic signed [32:0] mul_sel;
   logic signed [32:0] mul_opnd;
   logic signed [51:0] mul_full;
   logic signed [51:0] mul_round;
   logic signed [19:0] dz, dx;
   logic [19:0]        dz_mag, dx_mag;
   logic [21:0]        zpos;
   logic [43:0]        ang_prod;
   logic [8:0]         ang_quo;
   logic [18:0]        rsum, rdif;

   assign range_diff = $signed({1'b0, cfg.range_max_mm}) - $signed({1'b0, cfg.range_min_mm});
   assign diff_mag   = range_diff[18] ? 18'(-range_diff) : range_diff[17:0];
   assign code_m1    = item_ff.code - 16'd1;
   assign row_prod   = 23'(item_ff.row) * 23'(cfg.angle_step_urad);

   // Remainder of the halved range product after the estimated quotient.
   // The estimate is at most two below the true quotient.
   assign rem_full = prod_ff[33:1] - {div_quo_ff, 15'd0} + 33'(div_quo_ff);

   assign atan_val = rcga_pkg::atan_urad(cnt_ff);

   // Shared multiplier for height and forward distance.
   assign mul_sel   = (state_ff == rcga_pkg::BK_MUL_Z) ? ry_ff : rx_ff;
   assign mul_opnd  = neg_ff ? -mul_sel : mul_sel;
   assign mul_full  = $signed({1'b0, range_ff}) * mul_opnd;
   assign mul_round = mul_full + rcga_pkg::ROUND_HALF;

   assign dz     = {last_z_ff[18], last_z_ff} - {hz_ff[18], hz_ff};
   assign dx     = {last_x_ff[18], last_x_ff} - {fx_ff[18], fx_ff};
   assign dz_mag = dz[19] ? 20'(-dz) : dz;
   assign dx_mag = dx[19] ? 20'(-dx) : dx;
   assign zpos   = vz_ff[22] ? '0 : vz_ff[21:0];
   assign rsum   = {1'b0, cfg.range_min_mm} + {1'b0, div_quo_ff};
   assign rdif   = {1'b0, cfg.range_min_mm} - {1'b0, div_quo_ff};

   // Angle over 10000: the reciprocal product shifted right by 35 is exact here.
   assign ang_prod = 44'(zpos) * 44'(rcga_pkg::ANGLE_RECIP);
   assign ang_quo  = ang_prod[43:35];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcga_pkg::BK_IDLE: begin
            if (item_valid && !res_full) state_in = rcga_pkg::BK_CHECK;
         end
         rcga_pkg::BK_CHECK: begin
            if (item_ff.kind == rcga_pkg::KIND_PIXEL) state_in = rcga_pkg::BK_PREP;
            else state_in = rcga_pkg::BK_DONE;
         end
         rcga_pkg::BK_PREP: state_in = rcga_pkg::BK_DIV;
         rcga_pkg::BK_DIV:  state_in = rcga_pkg::BK_FIX;
         rcga_pkg::BK_FIX:  state_in = rcga_pkg::BK_FOLD;
         rcga_pkg::BK_FOLD: state_in = rcga_pkg::BK_ROT;
         rcga_pkg::BK_ROT: begin
            if (cnt_ff == 5'(rcga_pkg::CORDIC_ITERS - 1)) state_in = rcga_pkg::BK_MUL_Z;
         end
         rcga_pkg::BK_MUL_Z: state_in = rcga_pkg::BK_MUL_X;
         rcga_pkg::BK_MUL_X: state_in = rcga_pkg::BK_DIFF;
         rcga_pkg::BK_DIFF: begin
            if (item_ff.col == last_col_ff && (dz != '0 || dx != '0)) begin
               state_in = rcga_pkg::BK_VEC;
            end else begin
               state_in = rcga_pkg::BK_DONE;
            end
         end
         rcga_pkg::BK_VEC: begin
            if (cnt_ff == 5'(rcga_pkg::CORDIC_ITERS - 1)) state_in = rcga_pkg::BK_RESULT;
         end
         rcga_pkg::BK_RESULT: state_in = rcga_pkg::BK_DONE;
         rcga_pkg::BK_DONE:   state_in = rcga_pkg::BK_IDLE;
         default:             state_in = rcga_pkg::BK_IDLE;
      endcase
   end

   // Datapath and handshake outputs.
   always_comb begin
      item_pop    = 1'b0;
      res_push    = 1'b0;
      item_in     = item_ff;
      cnt_in      = cnt_ff;
      prod_in     = prod_ff;
      rneg_in     = rneg_ff;
      elev_in     = elev_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      range_in    = range_ff;
      neg_in      = neg_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      hz_in       = hz_ff;
      fx_in       = fx_ff;
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      vz_in       = vz_ff;
      acode_in    = acode_ff;
      written_in  = written_ff;
      last_col_in = last_col_ff;
      last_z_in   = last_z_ff;
      last_x_in   = last_x_ff;
      case (state_ff)
         rcga_pkg::BK_IDLE: begin
            if (item_valid && !res_full) begin
               item_pop = 1'b1;
               item_in  = item_data;
            end
         end
         rcga_pkg::BK_CHECK: begin
            // Range product and raw elevation.
            acode_in   = '0;
            written_in = 1'b0;
            prod_in    = {18'd0, code_m1} * {16'd0, diff_mag};
            rneg_in    = range_diff[18];
            elev_in    = $signed({2'b00, row_prod}) -
                         $signed({4'b0000, cfg.angle_span_urad[21:1]});
         end
         rcga_pkg::BK_PREP: begin
            // Quotient estimate from the first two terms of 1/(2^15 - 1), and the
            // elevation brought into [-pi, pi].
            div_quo_in = prod_ff[33:16] + 18'(prod_ff[33:31]);
            if (elev_ff > rcga_pkg::PI_URAD) begin
               elev_in = elev_ff - rcga_pkg::TWO_PI_URAD;
            end else if (elev_ff < -rcga_pkg::PI_URAD) begin
               elev_in = elev_ff + rcga_pkg::TWO_PI_URAD;
            end
         end
         rcga_pkg::BK_DIV: div_rem_in = rem_full[16:0];
         rcga_pkg::BK_FIX: begin
            // Raise the estimate by as many divisors as the remainder holds.
            if (div_rem_ff >= rcga_pkg::RANGE_REM_TWO) begin
               div_quo_in = div_quo_ff + 18'd2;
            end else if (div_rem_ff >= rcga_pkg::RANGE_REM_ONE) begin
               div_quo_in = div_quo_ff + 18'd1;
            end
         end
         rcga_pkg::BK_FOLD: begin
            // Decoded range, and the elevation folded into [-pi/2, pi/2].
            range_in = rneg_ff ? rdif[17:0] : rsum[17:0];
            neg_in   = 1'b0;
            if (elev_ff > rcga_pkg::HALF_PI_URAD) begin
               elev_in = elev_ff - rcga_pkg::PI_URAD;
               neg_in  = 1'b1;
            end else if (elev_ff < -rcga_pkg::HALF_PI_URAD) begin
               elev_in = elev_ff + rcga_pkg::PI_URAD;
               neg_in  = 1'b1;
            end
            rx_in  = rcga_pkg::CORDIC_GAIN_START;
            ry_in  = '0;
            cnt_in = '0;
         end
         rcga_pkg::BK_ROT: begin
            // One rotation step toward the residual angle.
            if (!elev_ff[24]) begin
               rx_in   = rx_ff - (ry_ff >>> cnt_ff);
               ry_in   = ry_ff + (rx_ff >>> cnt_ff);
               elev_in = elev_ff - $signed({5'd0, atan_val});
            end else begin
               rx_in   = rx_ff + (ry_ff >>> cnt_ff);
               ry_in   = ry_ff - (rx_ff >>> cnt_ff);
               elev_in = elev_ff + $signed({5'd0, atan_val});
            end
            cnt_in = cnt_ff + 5'd1;
         end
         rcga_pkg::BK_MUL_Z: hz_in = mul_round[48:30];
         rcga_pkg::BK_MUL_X: fx_in = mul_round[48:30];
         rcga_pkg::BK_DIFF: begin
            // Set up the vectoring pass and keep this point.
            vx_in       = $signed({3'd0, dx_mag, 20'd0});
            vy_in       = $signed({3'd0, dz_mag, 20'd0});
            vz_in       = '0;
            cnt_in      = '0;
            acode_in    = '0;
            written_in  = (item_ff.col == last_col_ff);
            last_col_in = item_ff.col;
            last_z_in   = hz_ff;
            last_x_in   = fx_ff;
         end
         rcga_pkg::BK_VEC: begin
            // One vectoring step toward the x axis.
            if (vy_ff > 43'sd0) begin
               vx_in = vx_ff + (vy_ff >>> cnt_ff);
               vy_in = vy_ff - (vx_ff >>> cnt_ff);
               vz_in = vz_ff + $signed({3'd0, atan_val});
            end else begin
               vx_in = vx_ff - (vy_ff >>> cnt_ff);
               vy_in = vy_ff + (vx_ff >>> cnt_ff);
               vz_in = vz_ff - $signed({3'd0, atan_val});
            end
            cnt_in = cnt_ff + 5'd1;
         end
         rcga_pkg::BK_RESULT: begin
            acode_in   = (ang_quo > rcga_pkg::ANGLE_LIMIT) ?
                         rcga_pkg::ANGLE_LIMIT[7:0] : ang_quo[7:0];
            written_in = 1'b1;
         end
         rcga_pkg::BK_DONE: res_push = 1'b1;
         default: ;
      endcase
   end

   assign res_data.angle_code    = acode_ff;
   assign res_data.angle_written = written_ff;

   // Control state and the kept point.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rcga_pkg::BK_IDLE;
         last_col_ff <= rcga_pkg::LAST_COL_RESET;
         last_z_ff   <= '0;
         last_x_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         last_col_ff <= last_col_in;
         last_z_ff   <= last_z_in;
         last_x_ff   <= last_x_in;
      end
   end

   // Working registers need no reset.
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      cnt_ff     <= cnt_in;
      prod_ff    <= prod_in;
      rneg_ff    <= rneg_in;
      elev_ff    <= elev_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      range_ff   <= range_in;
      neg_ff     <= neg_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      hz_ff      <= hz_in;
      fx_ff      <= fx_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      vz_ff      <= vz_in;
      acode_ff   <= acode_in;
      written_ff <= written_in;
   end

endmodule
